FILE: design/lmb_pkg.sv
// Shared types and constants for the layered material blend block.
package lmb_pkg;

    // Width of every value field on the ports
    localparam int FIELD_W = 13;
    localparam int MODE_W = 2;

    // Default fraction width: 1.0 is 2^FRAC_BITS_DEF
    localparam int FRAC_BITS_DEF = 12;

    // Lanes: three albedo channels, then roughness, metallic, occlusion
    localparam int NUM_LANES = 6;
    localparam int NUM_COLOR = 3;
    localparam int LANE_RED = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE = 2;
    localparam int LANE_ROUGH = 3;
    localparam int LANE_METAL = 4;
    localparam int LANE_OCCL = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_MULTIPLY = 2'd1,
        MODE_ADD      = 2'd2,
        MODE_OVERLAY  = 2'd3
    } mix_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LERP = 1'b1
    } ctrl_state_t;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic capture;
        logic commit;
        logic first;
    } lane_ctrl_t;

    // One input item: one material layer
    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
        logic [FIELD_W-1:0] rough_in;
        logic [FIELD_W-1:0] metal_in;
        logic [FIELD_W-1:0] occlusion_in;
        logic [FIELD_W-1:0] opacity;
        logic [MODE_W-1:0]  mix_op;
        logic               first_layer;
        logic               last_layer;
    } in_item_t;

    // One result item: the composited material
    typedef struct packed {
        logic [FIELD_W-1:0] red_out;
        logic [FIELD_W-1:0] green_out;
        logic [FIELD_W-1:0] blue_out;
        logic [FIELD_W-1:0] rough_out;
        logic [FIELD_W-1:0] metal_out;
        logic [FIELD_W-1:0] occlusion_out;
    } out_item_t;

endpackage

FILE: design/lmb_lane.sv
// One compositing lane: blend against the accumulator, then lerp by opacity.
module lmb_lane
    import lmb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lane_ctrl_t           ctrl,
    input  logic [FIELD_W-1:0]   layer_raw,
    input  logic [FIELD_W-1:0]   opacity_raw,
    input  mix_op_t              mode,
    output logic [FRAC_BITS:0]   acc
);

    localparam int VW = FRAC_BITS + 1;
    localparam int CW = (VW > FIELD_W) ? VW : FIELD_W;
    localparam int PW = 2 * VW;
    localparam int LW = 2 * VW + 2;
    localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF_V = VW'(1) << (FRAC_BITS - 1);

    logic [VW-1:0] acc_reg;
    logic [VW-1:0] acc_next;
    logic [VW-1:0] r_reg;
    logic [VW-1:0] r_next;
    logic [VW-1:0] layer_reg;
    logic [VW-1:0] t_reg;

    logic [VW-1:0] layer_sat;
    logic [VW-1:0] t_sat;
    logic          acc_low;
    logic [VW-1:0] mul_a;
    logic [VW-1:0] mul_b;
    logic [PW-1:0] blend_prod;
    logic [PW:0]   blend_scaled;
    logic [PW:0]   blend_sum;
    logic [VW-1:0] blend_rnd;
    logic [VW:0]   add_sum;

    logic signed [VW:0]   lerp_diff;
    logic signed [VW:0]   lerp_t;
    logic signed [LW-1:0] lerp_prod;
    logic signed [LW-1:0] lerp_base;
    logic signed [LW-1:0] lerp_sum;

    // Clamp a field to 1.0
    function automatic logic [VW-1:0] sat_one(input logic [FIELD_W-1:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        if (ve > ONE_C) begin
            return ONE_V;
        end
        return VW'(ve);
    endfunction

    assign layer_sat = sat_one(layer_raw);
    assign t_sat = sat_one(opacity_raw);
    assign acc_low = (acc_reg < HALF_V);

    // Blend the incoming layer against the accumulator
    always_comb begin
        if (mode == MODE_OVERLAY && !acc_low) begin
            mul_a = ONE_V - acc_reg;
            mul_b = ONE_V - layer_sat;
        end else begin
            mul_a = acc_reg;
            mul_b = layer_sat;
        end
        blend_prod = PW'(mul_a) * PW'(mul_b);
        if (mode == MODE_OVERLAY) begin
            blend_scaled = {blend_prod, 1'b0};
        end else begin
            blend_scaled = {1'b0, blend_prod};
        end
        blend_sum = blend_scaled + (PW + 1)'(HALF_V);
        blend_rnd = blend_sum[FRAC_BITS +: VW];
        add_sum = {1'b0, acc_reg} + {1'b0, layer_sat};

        unique case (mode)
            MODE_NORMAL: begin
                r_next = layer_sat;
            end
            MODE_MULTIPLY: begin
                r_next = blend_rnd;
            end
            MODE_ADD: begin
                r_next = (add_sum > {1'b0, ONE_V}) ? ONE_V : add_sum[VW-1:0];
            end
            MODE_OVERLAY: begin
                r_next = acc_low ? blend_rnd : (ONE_V - blend_rnd);
            end
        endcase
    end

    // Lerp: acc*ONE + (r - acc)*t, rounded once; a first layer loads the layer value instead
    always_comb begin
        lerp_diff = $signed({1'b0, r_reg}) - $signed({1'b0, acc_reg});
        lerp_t = $signed({1'b0, t_reg});
        lerp_prod = LW'(lerp_diff) * LW'(lerp_t);
        lerp_base = $signed(LW'(acc_reg) << FRAC_BITS);
        lerp_sum = lerp_base + lerp_prod + $signed(LW'(HALF_V));
        acc_next = ctrl.first ? layer_reg : lerp_sum[FRAC_BITS +: VW];
    end

    // Capture the layer and its blend on accept
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            r_reg <= r_next;
            layer_reg <= layer_sat;
            t_reg <= t_sat;
        end
    end

    // Update the accumulator on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.commit) begin
            acc_reg <= acc_next;
        end
    end

    // Present the value that the commit writes, so the merge stage sees this layer
    assign acc = acc_next;

endmodule

FILE: design/lmb_merge.sv
// Merging stage: gathers the lane accumulators into the output register.
module lmb_merge
    import lmb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  logic [NUM_LANES-1:0][FRAC_BITS:0]  lane_acc,
    output logic                               out_free,
    output logic                               m_valid,
    input  logic                               m_ready,
    output out_item_t                          m_data
);

    logic      m_valid_reg;
    out_item_t m_data_reg;
    out_item_t m_data_next;

    // Fit each lane value to the field width
    always_comb begin
        m_data_next.red_out       = FIELD_W'(lane_acc[LANE_RED]);
        m_data_next.green_out     = FIELD_W'(lane_acc[LANE_GREEN]);
        m_data_next.blue_out      = FIELD_W'(lane_acc[LANE_BLUE]);
        m_data_next.rough_out     = FIELD_W'(lane_acc[LANE_ROUGH]);
        m_data_next.metal_out     = FIELD_W'(lane_acc[LANE_METAL]);
        m_data_next.occlusion_out = FIELD_W'(lane_acc[LANE_OCCL]);
    end

    assign out_free = !m_valid_reg || m_ready;

    // Hold the result item until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

FILE: design/layered_material_blend.sv
// A top layer's result item is registered at the end of the lerp state after its accept,
// later only while the output register still holds an earlier item.
// A new layer item is accepted only from idle, after the accumulator loop of the last one
// (blend multiply in the accept cycle, lerp multiply in the lerp state) in each of six lanes.
// A top layer holds in the lerp cycle while the output register still holds an item.
// Reset clears all accumulators to zero, returns the sequencer to idle and empties
// the output register.
module layered_material_blend
    import lmb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        first_reg;
    logic        last_reg;
    logic        accept;
    logic        out_free;
    logic        push;
    lane_ctrl_t  lane_ctrl;

    logic [NUM_LANES-1:0][FIELD_W-1:0]  lane_raw;
    logic [NUM_LANES-1:0][FRAC_BITS:0]  lane_acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;

    // Sequence capture then commit for each layer
    always_comb begin
        state_next = state_reg;
        lane_ctrl.capture = accept;
        lane_ctrl.first = first_reg;
        lane_ctrl.commit = 1'b0;
        push = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LERP;
                end
            end
            ST_LERP: begin
                if (!last_reg || out_free) begin
                    lane_ctrl.commit = 1'b1;
                    push = last_reg;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                first_reg <= s_data.first_layer;
                last_reg <= s_data.last_layer;
            end
        end
    end

    // Route the item fields to the lanes
    always_comb begin
        lane_raw[LANE_RED]   = s_data.red;
        lane_raw[LANE_GREEN] = s_data.green;
        lane_raw[LANE_BLUE]  = s_data.blue;
        lane_raw[LANE_ROUGH] = s_data.rough_in;
        lane_raw[LANE_METAL] = s_data.metal_in;
        lane_raw[LANE_OCCL]  = s_data.occlusion_in;
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        mix_op_t lane_mode;

        // Scalar lanes always lerp toward the layer value
        if (i < NUM_COLOR) begin : g_color
            assign lane_mode = mix_op_t'(s_data.mix_op);
        end else begin : g_scalar
            assign lane_mode = MODE_NORMAL;
        end

        lmb_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk(aclk),
            .aresetn(aresetn),
            .ctrl(lane_ctrl),
            .layer_raw(lane_raw[i]),
            .opacity_raw(s_data.opacity),
            .mode(lane_mode),
            .acc(lane_acc[i])
        );
    end

    lmb_merge #(
        .FRAC_BITS(FRAC_BITS)
    ) u_merge (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .lane_acc(lane_acc),
        .out_free(out_free),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

endmodule
